[rtl/rmst_pkg.sv]
// ============================================================================
// rmst_pkg
// Shared types, constants and helpers for the range maximum segment tree.
// ============================================================================
package rmst_pkg;

    // Tree geometry: LEAVES leaves, node 1 is the root, leaf k is node LEAVES+k.
    localparam int LEVELS  = 10;
    localparam int LEAVES  = 1 << LEVELS;
    localparam int NODES   = 2 * LEAVES;
    localparam int ADDR_W  = LEVELS + 1;
    localparam int BOUND_W = LEVELS + 2;

    // Request and result field widths.
    localparam int POS_W  = 10;
    localparam int BND_W  = 11;
    localparam int DATA_W = 32;

    // Value of every node after reset, and the floor of every query answer.
    localparam logic signed [DATA_W-1:0] RESET_NODE = -32'sd1;
    localparam logic signed [DATA_W-1:0] EMPTY_MAX  = -32'sd1000000;

    // Request opcodes.
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QUERY,
        ST_FINISH
    } state_t;

    // Signed maximum of two node values.
    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

[rtl/range_max_segment_tree_core.sv]
// ============================================================================
// range_max_segment_tree_core
// Bottom-up segment tree over signed 32-bit leaves with point update and
// half-open range maximum query, held in one synchronous node memory.
// ============================================================================
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, op, position, value,  | sink
//          | left, right                               |
//  out     | out_valid, out_ready, range_max           | source
//
// A set request writes the leaf when it is taken, then each ancestor in
// turn, each reading the sibling through the memory's registered port.
// A query request is taken in the idle state, then walks the levels in the
// query state (both bounds read on two read ports) until it sees the bounds
// meet, and makes a final fold into the output register once it has space.
// After reset all NODES entries of the node memory are cleared, one entry
// a cycle, with in_ready low. A set request gives no result. A finished
// query waits in the output register while the next request is taken.

module range_max_segment_tree_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [rmst_pkg::POS_W-1:0]          position,
    input  logic signed [rmst_pkg::DATA_W-1:0]  value,
    input  logic [rmst_pkg::BND_W-1:0]          left,
    input  logic [rmst_pkg::BND_W-1:0]          right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rmst_pkg::DATA_W-1:0]  range_max
);

    localparam int ADDR_W  = rmst_pkg::ADDR_W;
    localparam int BOUND_W = rmst_pkg::BOUND_W;
    localparam int DATA_W  = rmst_pkg::DATA_W;

    // Node memory: one write port, two registered read ports.
    logic signed [DATA_W-1:0] node_mem [rmst_pkg::NODES];

    rmst_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic [ADDR_W-1:0]         node_reg;
    logic signed [DATA_W-1:0]  cur_reg;
    logic [BOUND_W-1:0]        lo_reg, hi_reg;
    logic signed [DATA_W-1:0]  best_reg;
    logic                      pend_a_reg, pend_b_reg;
    logic signed [DATA_W-1:0]  rd_a_reg, rd_b_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  range_max_reg;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;

    logic                      accept;
    logic                      out_space;
    logic                      clr_done;
    logic [ADDR_W-1:0]         leaf_node;
    logic [ADDR_W-1:0]         parent;
    logic signed [DATA_W-1:0]  upd_max;
    logic                      q_active;
    logic [BOUND_W-1:0]        hi_dec;
    logic [BOUND_W-1:0]        lo_next, hi_next;
    logic [BOUND_W-1:0]        lo_start, hi_start;
    logic [rmst_pkg::BND_W-1:0] left_sat, right_sat;
    logic signed [DATA_W-1:0]  fold_a, fold;

    // Handshake and shared decode.
    assign accept    = in_valid && in_ready;
    assign out_space = !out_valid_reg || out_ready;
    assign clr_done  = (clr_cnt_reg == ADDR_W'(rmst_pkg::NODES - 1));
    assign leaf_node = {1'b1, position[rmst_pkg::LEVELS-1:0]};
    assign parent    = node_reg >> 1;
    assign upd_max   = rmst_pkg::smax(cur_reg, rd_a_reg);

    // Query bounds are saturated to the leaf count and moved to node numbers.
    assign left_sat  = (left > rmst_pkg::BND_W'(rmst_pkg::LEAVES))
                       ? rmst_pkg::BND_W'(rmst_pkg::LEAVES) : left;
    assign right_sat = (right > rmst_pkg::BND_W'(rmst_pkg::LEAVES))
                       ? rmst_pkg::BND_W'(rmst_pkg::LEAVES) : right;
    assign lo_start  = BOUND_W'(left_sat) + BOUND_W'(rmst_pkg::LEAVES);
    assign hi_start  = BOUND_W'(right_sat) + BOUND_W'(rmst_pkg::LEAVES);

    // One level of the query climb.
    assign q_active = (lo_reg < hi_reg);
    assign hi_dec   = hi_reg - BOUND_W'(1);
    assign lo_next  = (lo_reg + BOUND_W'(lo_reg[0])) >> 1;
    assign hi_next  = hi_reg >> 1;

    // Fold the node values read in the previous cycle into the running max.
    assign fold_a = pend_a_reg ? rmst_pkg::smax(best_reg, rd_a_reg) : best_reg;
    assign fold   = pend_b_reg ? rmst_pkg::smax(fold_a, rd_b_reg) : fold_a;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmst_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == rmst_pkg::OP_SET) ? rmst_pkg::ST_UPDATE
                                                          : rmst_pkg::ST_QUERY;
                end
            end
            rmst_pkg::ST_UPDATE:
            begin
                if (parent == ADDR_W'(1))
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_QUERY:
            begin
                if (!q_active)
                begin
                    state_next = rmst_pkg::ST_FINISH;
                end
            end
            rmst_pkg::ST_FINISH:
            begin
                if (out_space)
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmst_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port control and handshake outputs.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = leaf_node;
        mem_wdata = value;
        rd_addr_a = lo_reg[ADDR_W-1:0];
        rd_addr_b = hi_dec[ADDR_W-1:0];
        in_ready  = 1'b0;
        unique case (state_reg)
            rmst_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = rmst_pkg::RESET_NODE;
            end
            rmst_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_we    = in_valid && (op == rmst_pkg::OP_SET);
                rd_addr_a = leaf_node ^ ADDR_W'(1);
            end
            rmst_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = upd_max;
                rd_addr_a = parent ^ ADDR_W'(1);
            end
            rmst_pkg::ST_QUERY:
            begin
            end
            rmst_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Node memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= node_mem[rd_addr_a];
        rd_b_reg <= node_mem[rd_addr_b];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmst_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_a_reg    <= 1'b0;
            pend_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rmst_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == rmst_pkg::ST_QUERY)
            begin
                pend_a_reg <= q_active && lo_reg[0];
                pend_b_reg <= q_active && hi_reg[0];
            end
            else
            begin
                pend_a_reg <= 1'b0;
                pend_b_reg <= 1'b0;
            end
            if (state_reg == rmst_pkg::ST_FINISH && out_space)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rmst_pkg::ST_IDLE:
            begin
                node_reg <= leaf_node;
                cur_reg  <= value;
                lo_reg   <= lo_start;
                hi_reg   <= hi_start;
                best_reg <= rmst_pkg::EMPTY_MAX;
            end
            rmst_pkg::ST_UPDATE:
            begin
                node_reg <= parent;
                cur_reg  <= upd_max;
            end
            rmst_pkg::ST_QUERY:
            begin
                lo_reg   <= lo_next;
                hi_reg   <= hi_next;
                best_reg <= fold;
            end
            rmst_pkg::ST_FINISH:
            begin
                best_reg <= fold;
                if (out_space)
                begin
                    range_max_reg <= fold;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign range_max = range_max_reg;

endmodule

[rtl/rmst_checker.sv]
// ============================================================================
// rmst_checker
// Port-level assertions for the range maximum segment tree, bound to the core.
// ============================================================================
module rmst_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                op,
    input logic [rmst_pkg::POS_W-1:0]          position,
    input logic signed [rmst_pkg::DATA_W-1:0]  value,
    input logic [rmst_pkg::BND_W-1:0]          left,
    input logic [rmst_pkg::BND_W-1:0]          right,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [rmst_pkg::DATA_W-1:0]  range_max
);

    logic unused_fields;

    // Request payload fields are not examined here.
    assign unused_fields = ^{position, value, left, right};

    // A stalled request stays offered.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request dropped while stalled");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(range_max))
        else $error("result changed while stalled");

    // A set request keeps the block busy in the next cycle.
    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == rmst_pkg::OP_SET |=> !in_ready)
        else $error("set request did not walk the tree");

    // No answer falls below the empty-range floor.
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> range_max >= rmst_pkg::EMPTY_MAX)
        else $error("result below floor");

endmodule

bind range_max_segment_tree_core rmst_checker u_rmst_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .position  (position),
    .value     (value),
    .left      (left),
    .right     (right),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .range_max (range_max)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for range_max_segment_tree_core: a shadow segment tree
// follows every accepted set request and predicts the answer of every query
// request, with random gaps and stalls on both handshakes.
// ============================================================================

// Shadow copy of the node store, with the answers still owed by the block.
class max_tree_tracker;

    logic signed [rmst_pkg::DATA_W-1:0] node_val [rmst_pkg::NODES];
    logic signed [rmst_pkg::DATA_W-1:0] owed_max [$];
    int fail_count;

    function new();
        foreach (node_val[i])
            node_val[i] = rmst_pkg::RESET_NODE;
        fail_count = 0;
    endfunction

    // Climb both bounds of [l, r) and keep the largest node met.
    function logic signed [rmst_pkg::DATA_W-1:0] predict_max(
        input logic [rmst_pkg::BND_W-1:0] l,
        input logic [rmst_pkg::BND_W-1:0] r
    );
        int lo;
        int hi;
        logic signed [rmst_pkg::DATA_W-1:0] best;
        lo   = (l > rmst_pkg::LEAVES) ? rmst_pkg::LEAVES : int'(l);
        hi   = (r > rmst_pkg::LEAVES) ? rmst_pkg::LEAVES : int'(r);
        lo   = lo + rmst_pkg::LEAVES;
        hi   = hi + rmst_pkg::LEAVES;
        best = rmst_pkg::EMPTY_MAX;
        while (lo < hi)
        begin
            if (lo % 2 == 1)
            begin
                if (node_val[lo] > best)
                    best = node_val[lo];
                lo = lo + 1;
            end
            if (hi % 2 == 1)
            begin
                hi = hi - 1;
                if (node_val[hi] > best)
                    best = node_val[hi];
            end
            lo = lo / 2;
            hi = hi / 2;
        end
        return best;
    endfunction

    // A set request rewrites one leaf and its ancestors; a query owes an answer.
    function void note_request(
        input logic                          op,
        input logic [rmst_pkg::POS_W-1:0]    pos,
        input logic signed [rmst_pkg::DATA_W-1:0] val,
        input logic [rmst_pkg::BND_W-1:0]    l,
        input logic [rmst_pkg::BND_W-1:0]    r
    );
        int node;
        int parent;
        if (op == rmst_pkg::OP_SET)
        begin
            node = rmst_pkg::LEAVES + (int'(pos) % rmst_pkg::LEAVES);
            node_val[node] = val;
            while (node > 1)
            begin
                parent = node / 2;
                node_val[parent] = (node_val[node] > node_val[node ^ 1]) ?
                                   node_val[node] : node_val[node ^ 1];
                node = parent;
            end
        end
        else
        begin
            owed_max.push_back(predict_max(l, r));
        end
    endfunction

    // Compare one answer from the block with the oldest one owed.
    function void check_range_max(input logic signed [rmst_pkg::DATA_W-1:0] actual);
        logic signed [rmst_pkg::DATA_W-1:0] want;
        if (owed_max.size() == 0)
        begin
            $display("%0t: range_max %0d arrived with no query outstanding",
                     $time, actual);
            fail_count++;
        end
        else
        begin
            want = owed_max.pop_front();
            if (actual !== want)
            begin
                $display("%0t: range_max mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                fail_count++;
            end
        end
    endfunction

    function int pending();
        return owed_max.size();
    endfunction

endclass

module tb_top;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic                                op;
    logic [rmst_pkg::POS_W-1:0]          position;
    logic signed [rmst_pkg::DATA_W-1:0]  value;
    logic [rmst_pkg::BND_W-1:0]          left;
    logic [rmst_pkg::BND_W-1:0]          right;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [rmst_pkg::DATA_W-1:0]  range_max;

    max_tree_tracker tracker = new();

    // Percentages of cycles in which each side holds back.
    int send_idle_pct;
    int recv_idle_pct;
    // Long receiver hold-off asked for by the stimulus, in cycles.
    int hold_request;

    range_max_segment_tree_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .position  (position),
        .value     (value),
        .left      (left),
        .right     (right),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .range_max (range_max)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("[range_max_segment_tree_core] ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request > 0)
            begin
                hold_left    = hold_request - 1;
                hold_request = 0;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every answer taken from the block is checked at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            tracker.check_range_max(range_max);
    end

    // Offer one request, with random idle cycles ahead of it, and wait for it
    // to be taken.
    task automatic send_request(
        input logic                                o,
        input logic [rmst_pkg::POS_W-1:0]          p,
        input logic signed [rmst_pkg::DATA_W-1:0]  v,
        input logic [rmst_pkg::BND_W-1:0]          l,
        input logic [rmst_pkg::BND_W-1:0]          r
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        position <= p;
        value    <= v;
        left     <= l;
        right    <= r;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(o, p, v, l, r);
    endtask

    // Leaf values: full range, a band around zero, or hugging the query floor.
    function automatic logic signed [rmst_pkg::DATA_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0)
            return $urandom();
        else if (pick == 1)
            return int'($urandom_range(4000000)) - 2000000;
        else
            return int'($urandom_range(2000)) - 1001000;
    endfunction

    task automatic send_random_query();
        logic [rmst_pkg::BND_W-1:0] l;
        logic [rmst_pkg::BND_W-1:0] r;
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            // Proper range, often narrow.
            l = rmst_pkg::BND_W'($urandom_range(rmst_pkg::LEAVES - 1));
            if ($urandom_range(1) == 0)
            begin
                span = int'(l) + 1 + int'($urandom_range(15));
                r = (span > rmst_pkg::LEAVES) ? rmst_pkg::BND_W'(rmst_pkg::LEAVES)
                                               : rmst_pkg::BND_W'(span);
            end
            else
                r = rmst_pkg::BND_W'($urandom_range(rmst_pkg::LEAVES, int'(l) + 1));
        end
        else if (pick < 85)
        begin
            // Any bounds, including those past the end of the tree.
            l = rmst_pkg::BND_W'($urandom_range(2047));
            r = rmst_pkg::BND_W'($urandom_range(2047));
        end
        else
        begin
            // Empty or reversed range.
            l = rmst_pkg::BND_W'($urandom_range(rmst_pkg::LEAVES));
            r = rmst_pkg::BND_W'($urandom_range(int'(l)));
        end
        send_request(rmst_pkg::OP_QUERY, rmst_pkg::POS_W'($urandom()), $urandom(), l, r);
    endtask

    task automatic send_random_request();
        if ($urandom_range(1) == 0)
            send_request(rmst_pkg::OP_SET, rmst_pkg::POS_W'($urandom()), pick_value(),
                         rmst_pkg::BND_W'($urandom()), rmst_pkg::BND_W'($urandom()));
        else
            send_random_query();
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Main stimulus.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = rmst_pkg::OP_SET;
        position      = '0;
        value         = '0;
        left          = '0;
        right         = '0;
        hold_request  = 0;
        send_idle_pct = 33;
        recv_idle_pct = 59;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: queries over the cleared tree, empty, reversed and
        // out-of-range bounds.
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd0, 11'd1024);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd5, 11'd5);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd10, 11'd3);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd2047, 11'd2047);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd0, 11'd2047);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd1024, 11'd1024);

        // Directed: extreme values at both ends of the tree.
        send_request(rmst_pkg::OP_SET, 10'd0, 32'sh7FFF_FFFF, '0, '0);
        send_request(rmst_pkg::OP_SET, 10'd1023, 32'sh8000_0000, '0, '0);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd0, 11'd1);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd1023, 11'd1024);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd1023, 11'd2047);

        // Directed: values at and just above the query floor.
        send_request(rmst_pkg::OP_SET, 10'd1023, rmst_pkg::EMPTY_MAX, '1, '1);
        send_request(rmst_pkg::OP_QUERY, '1, '1, 11'd1023, 11'd1024);
        send_request(rmst_pkg::OP_SET, 10'd1023, rmst_pkg::EMPTY_MAX + 1, '0, '0);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd1000, 11'd1024);

        // Directed: replace the maximum, then alternating bit patterns.
        send_request(rmst_pkg::OP_SET, 10'd0, -32'sd5, '0, '0);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd0, 11'd1024);
        send_request(rmst_pkg::OP_SET, 10'd512, 32'sd12345, '0, '0);
        send_request(rmst_pkg::OP_QUERY, '0, '0, 11'd1, 11'd1023);
        send_request(rmst_pkg::OP_SET, 10'h155, 32'sh5555_5555, 11'h2AA, 11'h555);
        send_request(rmst_pkg::OP_SET, 10'h2AA, 32'shAAAA_AAAA, 11'h555, 11'h2AA);
        send_request(rmst_pkg::OP_QUERY, 10'h155, 32'sh5555_5555, 11'h155, 11'h2AB);
        send_request(rmst_pkg::OP_QUERY, 10'h2AA, 32'shAAAA_AAAA, 11'h2AA, 11'h400);

        // Random phases: sender idles less than the receiver, then the
        // other way round, then neither idles.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 33 : 0;
            if (phase == 0)
            begin
                // Hold the answers back so the block fills and stalls intake.
                hold_request = 400;
                repeat (40) send_random_query();
            end
            repeat (255) send_random_request();
            // Sender pauses until every answer owed has come back.
            @(negedge clk);
            in_valid <= 1'b0;
            wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (tracker.fail_count == 0)
            $display("[range_max_segment_tree_core] OK");
        else
            $display("[range_max_segment_tree_core] ERROR");
        $finish;
    end

endmodule
